// ----- hdl/lsct_pkg.sv -----
// ============================================================================
// lsct_pkg: shared types and constants of the laser spot centroid tracker
// Field widths, register indexes, reset values and the beat structs passed
// between the front end, the queue and the back end.
// ============================================================================
package lsct_pkg;

    localparam int GREEN_W    = 8;
    localparam int COORD_W    = 12;
    localparam int HALF_W     = 11;
    localparam int DIM_W      = 13;
    localparam int COUNT_W    = 25;
    localparam int SUM_W      = 37;
    localparam int FRAME_W    = 32;
    localparam int CENT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_DIM           = 4096;
    localparam int FRAC_BITS_DEFAULT = 4;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [COORD_W-1:0] LIM_MAX   = COORD_W'(MAX_DIM - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CENT_W-1:0]  CENT_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FRAME = 3'd5;

    localparam logic [GREEN_W-1:0] THRESHOLD_RST = 8'd50;
    localparam logic [HALF_W-1:0]  HALF_SIZE_RST = 11'd75;
    localparam logic [DIM_W-1:0]   WIDTH_RST     = 13'd1920;
    localparam logic [DIM_W-1:0]   HEIGHT_RST    = 13'd1080;

    typedef struct packed {
        logic [GREEN_W-1:0] green_value;
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic               frame_last;
    } in_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               spot_found;
        logic [CENT_W-1:0]  centroid_col;
        logic [CENT_W-1:0]  centroid_row;
    } out_item_t;

    typedef struct packed {
        logic               lit;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } q_item_t;

    typedef struct packed {
        logic [GREEN_W-1:0] threshold;
        logic               window_enable;
        logic [HALF_W-1:0]  half_size;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
    } cfg_t;

    typedef struct packed {
        logic               spot_valid;
        logic [COORD_W-1:0] col_start;
        logic [COORD_W-1:0] col_stop;
        logic [COORD_W-1:0] row_start;
        logic [COORD_W-1:0] row_stop;
    } window_t;

endpackage

// ----- hdl/lsct_queue.sv -----
// ============================================================================
// lsct_queue: short beat queue between front end and back end
// Register-based FIFO; lets each side stall independently.
// ============================================================================
module lsct_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lsct_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output lsct_pkg::q_item_t pop_item
);

    localparam int PTR_W = (lsct_pkg::QUEUE_DEPTH > 1) ? $clog2(lsct_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lsct_pkg::QUEUE_DEPTH + 1);

    lsct_pkg::q_item_t mem_reg [lsct_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(lsct_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lsct_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lsct_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/lsct_front.sv -----
// ============================================================================
// lsct_front: pixel intake and classification
// Marks each pixel lit when above threshold and inside the active window,
// and holds off new pixels after a frame end until the back end is done.
// ============================================================================
module lsct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lsct_pkg::in_item_t in_data,
    input  lsct_pkg::cfg_t     cfg,
    input  lsct_pkg::window_t  window,
    input  logic              frame_done,
    input  logic              q_full,
    output logic              q_push,
    output lsct_pkg::q_item_t  q_item
);

    logic frame_wait_reg, frame_wait_next;
    logic in_win;

    assign in_ready = !q_full && !frame_wait_reg;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        in_win = 1'b1;
        if (cfg.window_enable && window.spot_valid)
        begin
            in_win = (in_data.pixel_col >= window.col_start) &&
                     (in_data.pixel_col <  window.col_stop)  &&
                     (in_data.pixel_row >= window.row_start) &&
                     (in_data.pixel_row <  window.row_stop);
        end
        q_item.lit  = in_win && (in_data.green_value > cfg.threshold);
        q_item.col  = in_data.pixel_col;
        q_item.row  = in_data.pixel_row;
        q_item.last = in_data.frame_last;
    end

    always_comb
    begin
        frame_wait_next = frame_wait_reg;
        if (frame_done)
        begin
            frame_wait_next = 1'b0;
        end
        else if (q_push && in_data.frame_last)
        begin
            frame_wait_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_wait_reg <= 1'b0;
        end
        else
        begin
            frame_wait_reg <= frame_wait_next;
        end
    end

endmodule

// ----- hdl/lsct_back.sv -----
// ============================================================================
// lsct_back: accumulation, centroid division and window placement
// Sums lit pixels, runs a restoring divider at frame end (one quotient bit
// per cycle for both axes), places the next window and emits the report.
// ============================================================================
module lsct_back #(
    parameter int FRAC_BITS = lsct_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsct_pkg::cfg_t                     cfg,
    input  logic                              frame_load,
    input  logic [lsct_pkg::FRAME_W-1:0]      frame_load_value,
    input  logic                              q_empty,
    input  lsct_pkg::q_item_t                  q_item,
    output logic                              q_pop,
    output lsct_pkg::window_t                  window,
    output logic                              frame_done,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lsct_pkg::out_item_t                out_data
);

    localparam int CW     = lsct_pkg::COORD_W;
    localparam int NW     = lsct_pkg::COUNT_W;
    localparam int SW     = lsct_pkg::SUM_W;
    localparam int QW     = CW + FRAC_BITS;
    localparam int STEP_W = $clog2(QW + 1);

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    typedef struct packed {
        logic [CW-1:0] start;
        logic [CW-1:0] stop;
    } span_t;

    logic [2:0]                        state_reg, state_next;
    logic [NW-1:0]                     lit_count_reg, lit_count_next;
    logic [SW-1:0]                     col_sum_reg, col_sum_next;
    logic [SW-1:0]                     row_sum_reg, row_sum_next;
    logic [lsct_pkg::FRAME_W-1:0]      frame_counter_reg, frame_counter_next;
    lsct_pkg::window_t                  window_reg, window_next;
    logic                              out_valid_reg, out_valid_next;
    lsct_pkg::out_item_t                out_data_reg, out_data_next;
    lsct_pkg::out_item_t                res_reg, res_next;
    logic [NW-1:0]                     rem_col_reg, rem_col_next;
    logic [NW-1:0]                     rem_row_reg, rem_row_next;
    logic [QW-1:0]                     dvd_col_reg, dvd_col_next;
    logic [QW-1:0]                     dvd_row_reg, dvd_row_next;
    logic [QW-1:0]                     quo_col_reg, quo_col_next;
    logic [QW-1:0]                     quo_row_reg, quo_row_next;
    logic [STEP_W-1:0]                 step_reg, step_next;

    logic [NW:0] col_sh, row_sh, col_sub, row_sub;
    logic        col_ge, row_ge, found;
    span_t       col_span, row_span;

    function automatic span_t place_span(input logic [CW-1:0] c,
                                         input logic [lsct_pkg::HALF_W-1:0] h,
                                         input logic [lsct_pkg::DIM_W-1:0] dim);
        logic [CW-1:0]                s;
        logic [lsct_pkg::DIM_W-1:0]   lim;
        logic [lsct_pkg::DIM_W-1:0]   e;
        span_t                        r;
        s = (c > CW'(h)) ? c - CW'(h) : '0;
        if (s > lsct_pkg::LIM_MAX)
        begin
            s = lsct_pkg::LIM_MAX;
        end
        lim = (dim == '0) ? '0 : dim - 1'b1;
        if (lim > lsct_pkg::DIM_W'(lsct_pkg::LIM_MAX))
        begin
            lim = lsct_pkg::DIM_W'(lsct_pkg::LIM_MAX);
        end
        e = lsct_pkg::DIM_W'(s) + {1'b0, h, 1'b0};
        if (e > lim)
        begin
            e = lim;
        end
        r.start = s;
        r.stop  = CW'(e);
        return r;
    endfunction

    function automatic logic [lsct_pkg::CENT_W-1:0] sat_cent(input logic [QW-1:0] q);
        return (q > QW'(lsct_pkg::CENT_MAX)) ? lsct_pkg::CENT_MAX : lsct_pkg::CENT_W'(q);
    endfunction

    assign window     = window_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign q_pop      = (state_reg == ST_ACC) && !q_empty;
    assign frame_done = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign found      = (lit_count_reg != '0);

    // one restoring step per axis
    assign col_sh  = {rem_col_reg, dvd_col_reg[QW-1]};
    assign row_sh  = {rem_row_reg, dvd_row_reg[QW-1]};
    assign col_sub = col_sh - {1'b0, lit_count_reg};
    assign row_sub = row_sh - {1'b0, lit_count_reg};
    assign col_ge  = (col_sh >= {1'b0, lit_count_reg});
    assign row_ge  = (row_sh >= {1'b0, lit_count_reg});

    assign col_span = place_span(CW'(quo_col_reg >> FRAC_BITS), cfg.half_size, cfg.frame_width);
    assign row_span = place_span(CW'(quo_row_reg >> FRAC_BITS), cfg.half_size, cfg.frame_height);

    always_comb
    begin
        state_next         = state_reg;
        lit_count_next     = lit_count_reg;
        col_sum_next       = col_sum_reg;
        row_sum_next       = row_sum_reg;
        frame_counter_next = frame_counter_reg;
        window_next        = window_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        res_next           = res_reg;
        rem_col_next       = rem_col_reg;
        rem_row_next       = rem_row_reg;
        dvd_col_next       = dvd_col_reg;
        dvd_row_next       = dvd_row_reg;
        quo_col_next       = quo_col_reg;
        quo_row_next       = quo_row_reg;
        step_next          = step_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_ACC:
            begin
                if (!q_empty)
                begin
                    if (q_item.lit && (lit_count_reg != lsct_pkg::COUNT_MAX))
                    begin
                        lit_count_next = lit_count_reg + 1'b1;
                        col_sum_next   = col_sum_reg + SW'(q_item.col);
                        row_sum_next   = row_sum_reg + SW'(q_item.row);
                    end
                    if (q_item.last)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                // sum < count * 2^CW, so the top bits start below the divisor
                rem_col_next = col_sum_reg[SW-1:CW];
                rem_row_next = row_sum_reg[SW-1:CW];
                dvd_col_next = QW'(col_sum_reg[CW-1:0]) << FRAC_BITS;
                dvd_row_next = QW'(row_sum_reg[CW-1:0]) << FRAC_BITS;
                quo_col_next = '0;
                quo_row_next = '0;
                step_next    = STEP_W'(QW);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                rem_col_next = col_ge ? col_sub[NW-1:0] : col_sh[NW-1:0];
                rem_row_next = row_ge ? row_sub[NW-1:0] : row_sh[NW-1:0];
                dvd_col_next = dvd_col_reg << 1;
                dvd_row_next = dvd_row_reg << 1;
                quo_col_next = {quo_col_reg[QW-2:0], col_ge};
                quo_row_next = {quo_row_reg[QW-2:0], row_ge};
                step_next    = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                res_next.frame_number = frame_counter_reg;
                res_next.spot_found   = found;
                res_next.centroid_col = found ? sat_cent(quo_col_reg) : '0;
                res_next.centroid_row = found ? sat_cent(quo_row_reg) : '0;
                window_next.spot_valid = found;
                if (found)
                begin
                    window_next.col_start = col_span.start;
                    window_next.col_stop  = col_span.stop;
                    window_next.row_start = row_span.start;
                    window_next.row_stop  = row_span.stop;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (frame_done)
                begin
                    out_data_next      = res_reg;
                    out_valid_next     = 1'b1;
                    frame_counter_next = frame_counter_reg + 1'b1;
                    lit_count_next     = '0;
                    col_sum_next       = '0;
                    row_sum_next       = '0;
                    state_next         = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase

        if (frame_load)
        begin
            frame_counter_next = frame_load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_ACC;
            lit_count_reg     <= '0;
            col_sum_reg       <= '0;
            row_sum_reg       <= '0;
            frame_counter_reg <= '0;
            window_reg        <= '0;
            out_valid_reg     <= 1'b0;
            step_reg          <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            lit_count_reg     <= lit_count_next;
            col_sum_reg       <= col_sum_next;
            row_sum_reg       <= row_sum_next;
            frame_counter_reg <= frame_counter_next;
            window_reg        <= window_next;
            out_valid_reg     <= out_valid_next;
            step_reg          <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        rem_col_reg  <= rem_col_next;
        rem_row_reg  <= rem_row_next;
        dvd_col_reg  <= dvd_col_next;
        dvd_row_reg  <= dvd_row_next;
        quo_col_reg  <= quo_col_next;
        quo_row_reg  <= quo_row_next;
    end

    a_div_start_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && found) |->
            (col_sum_reg[SW-1:CW] < lit_count_reg && row_sum_reg[SW-1:CW] < lit_count_reg))
        else $error("divider start remainder not below lit count");

    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && found) |=>
            (rem_col_reg < lit_count_reg && rem_row_reg < lit_count_reg))
        else $error("divider remainder escaped its bound");

    a_done_returns_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (state_reg == ST_ACC && out_valid_reg))
        else $error("frame done without report or return to accumulate");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC) |=> $stable(lit_count_reg) || $past(frame_done))
        else $error("lit count moved outside accumulation");

endmodule

// ----- hdl/laser_spot_centroid_tracker_unit.sv -----
// ============================================================================
// laser_spot_centroid_tracker_unit: top level of the spot centroid tracker
// Configuration registers, front end, beat queue and back end.
// ============================================================================
// Pixel beats are taken one per clock while the queue has room. A beat with
// frame_last set is taken, then in_ready stays low until the frame is closed:
// the queue drains, the two restoring dividers produce 12 + FRAC_BITS
// quotient bits each at one bit per cycle for both axes, the next window is
// placed and the report is loaded into the output register once the previous
// report has been taken. Reports leave through a registered valid/ready
// output, one per frame. Configuration writes take effect at once and are
// meant for idle periods; writing first_frame_number also reloads the frame
// counter.
module laser_spot_centroid_tracker_unit #(
    parameter int FRAC_BITS = lsct_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [lsct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsct_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lsct_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lsct_pkg::out_item_t                out_data
);

    lsct_pkg::cfg_t    cfg_reg, cfg_next;
    lsct_pkg::window_t window;
    lsct_pkg::q_item_t push_item, pop_item;
    logic             q_push, q_pop, q_full, q_empty;
    logic             frame_done;
    logic             frame_load;

    assign frame_load = cfg_write_en && (cfg_index == lsct_pkg::REG_FIRST_FRAME);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                lsct_pkg::REG_THRESHOLD:    cfg_next.threshold     = cfg_data[lsct_pkg::GREEN_W-1:0];
                lsct_pkg::REG_WIN_ENABLE:   cfg_next.window_enable = cfg_data[0];
                lsct_pkg::REG_HALF_SIZE:    cfg_next.half_size     = cfg_data[lsct_pkg::HALF_W-1:0];
                lsct_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width   = cfg_data[lsct_pkg::DIM_W-1:0];
                lsct_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height  = cfg_data[lsct_pkg::DIM_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= lsct_pkg::THRESHOLD_RST;
            cfg_reg.window_enable <= 1'b0;
            cfg_reg.half_size     <= lsct_pkg::HALF_SIZE_RST;
            cfg_reg.frame_width   <= lsct_pkg::WIDTH_RST;
            cfg_reg.frame_height  <= lsct_pkg::HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .window     (window),
        .frame_done (frame_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    lsct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    lsct_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .frame_load       (frame_load),
        .frame_load_value (cfg_data[lsct_pkg::FRAME_W-1:0]),
        .q_empty          (q_empty),
        .q_item           (pop_item),
        .q_pop            (q_pop),
        .window           (window),
        .frame_done       (frame_done),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

endmodule
